[rtl/core/ted_pkg.sv]
// Shared types and codes for the terminal escape key decoder.
`timescale 1ns / 1ps
`default_nettype none
package ted_pkg;

  // Parser state, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_ESC  = 5'b00010,
    MODE_CSI  = 5'b00100,
    MODE_NUM  = 5'b01000,
    MODE_SS3  = 5'b10000
  } mode_t;

  // Key kinds
  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_PRINT   = 3'd1;
  localparam logic [2:0] KIND_ENTER   = 3'd2;
  localparam logic [2:0] KIND_TAB     = 3'd3;
  localparam logic [2:0] KIND_BKSP    = 3'd4;
  localparam logic [2:0] KIND_ESC     = 3'd5;
  localparam logic [2:0] KIND_NAV     = 3'd6;
  localparam logic [2:0] KIND_FKEY    = 3'd7;

  // Navigation codes
  localparam logic [3:0] NAV_UP    = 4'd0;
  localparam logic [3:0] NAV_DOWN  = 4'd1;
  localparam logic [3:0] NAV_LEFT  = 4'd2;
  localparam logic [3:0] NAV_RIGHT = 4'd3;
  localparam logic [3:0] NAV_HOME  = 4'd4;
  localparam logic [3:0] NAV_END   = 4'd5;
  localparam logic [3:0] NAV_PGUP  = 4'd6;
  localparam logic [3:0] NAV_PGDN  = 4'd7;
  localparam logic [3:0] NAV_INS   = 4'd8;
  localparam logic [3:0] NAV_DEL   = 4'd9;

  // Bytes of note
  localparam logic [7:0] BYTE_ESC   = 8'd27;
  localparam logic [7:0] BYTE_CSI   = 8'h5B; // '['
  localparam logic [7:0] BYTE_SS3   = 8'h4F; // 'O'
  localparam logic [7:0] BYTE_TILDE = 8'h7E;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_HT    = 8'd9;
  localparam logic [7:0] BYTE_BS    = 8'd8;
  localparam logic [7:0] BYTE_DEL   = 8'd127;

  localparam logic [6:0] ACC_MAX = 7'd99;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [6:0] char_code;
    logic [3:0] nav_index;
    logic [3:0] fkey_number;
  } key_t;

endpackage
`default_nettype wire

[rtl/core/ted_decode.sv]
// Next-state and key-event logic for one received byte or idle tick.
`timescale 1ns / 1ps
`default_nettype none
module ted_decode (
  input  var ted_pkg::mode_t mode,
  input  wire logic [6:0]    acc,
  input  wire logic          func,
  input  wire logic [7:0]    data_byte,
  output var ted_pkg::mode_t mode_nxt,
  output logic [6:0]         acc_nxt,
  output ted_pkg::key_t      key
);

  logic       is_digit;
  logic       is_lower;
  logic       is_upper;
  logic       is_punct;
  logic [3:0] digit_val;
  logic [9:0] acc_grow;
  ted_pkg::key_t plain_key;
  ted_pkg::key_t tilde_key;

  assign is_digit  = (data_byte >= 8'h30) && (data_byte <= 8'h39);
  assign is_lower  = (data_byte >= 8'h61) && (data_byte <= 8'h7A);
  assign is_upper  = (data_byte >= 8'h41) && (data_byte <= 8'h5A);
  assign digit_val = data_byte[3:0];
  // acc*10 + digit as acc*8 + acc*2 + digit
  assign acc_grow  = {acc, 3'b000} + {2'b00, acc, 1'b0} + {6'd0, digit_val};

  always_comb begin
    case (data_byte)
      8'h20, 8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h5C, 8'h3B, 8'h27, 8'h2C, 8'h2E, 8'h2F,
      8'h60, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28,
      8'h29: is_punct = 1'b1;
      default: is_punct = 1'b0;
    endcase
  end

  // Byte outside any sequence
  always_comb begin
    plain_key = '{valid: 1'b1, kind: ted_pkg::KIND_UNKNOWN, char_code: 7'd0,
                  nav_index: 4'd0, fkey_number: 4'd0};
    if (is_lower) begin
      plain_key.kind      = ted_pkg::KIND_PRINT;
      plain_key.char_code = data_byte[6:0] - 7'd32;
    end else if (is_upper || is_digit || is_punct) begin
      plain_key.kind      = ted_pkg::KIND_PRINT;
      plain_key.char_code = data_byte[6:0];
    end else if (data_byte == ted_pkg::BYTE_LF || data_byte == ted_pkg::BYTE_CR) begin
      plain_key.kind = ted_pkg::KIND_ENTER;
    end else if (data_byte == ted_pkg::BYTE_HT) begin
      plain_key.kind = ted_pkg::KIND_TAB;
    end else if (data_byte == ted_pkg::BYTE_BS || data_byte == ted_pkg::BYTE_DEL) begin
      plain_key.kind = ted_pkg::KIND_BKSP;
    end
  end

  // Number closed by '~'
  always_comb begin
    tilde_key = '{valid: 1'b1, kind: ted_pkg::KIND_UNKNOWN, char_code: 7'd0,
                  nav_index: 4'd0, fkey_number: 4'd0};
    case (acc)
      7'd1, 7'd7: begin
        tilde_key.kind = ted_pkg::KIND_NAV; tilde_key.nav_index = ted_pkg::NAV_HOME;
      end
      7'd2: begin
        tilde_key.kind = ted_pkg::KIND_NAV; tilde_key.nav_index = ted_pkg::NAV_INS;
      end
      7'd3: begin
        tilde_key.kind = ted_pkg::KIND_NAV; tilde_key.nav_index = ted_pkg::NAV_DEL;
      end
      7'd4, 7'd8: begin
        tilde_key.kind = ted_pkg::KIND_NAV; tilde_key.nav_index = ted_pkg::NAV_END;
      end
      7'd5: begin
        tilde_key.kind = ted_pkg::KIND_NAV; tilde_key.nav_index = ted_pkg::NAV_PGUP;
      end
      7'd6: begin
        tilde_key.kind = ted_pkg::KIND_NAV; tilde_key.nav_index = ted_pkg::NAV_PGDN;
      end
      7'd11, 7'd12, 7'd13, 7'd14, 7'd15: begin
        tilde_key.kind = ted_pkg::KIND_FKEY; tilde_key.fkey_number = 4'(acc - 7'd10);
      end
      7'd17, 7'd18, 7'd19, 7'd20, 7'd21: begin
        tilde_key.kind = ted_pkg::KIND_FKEY; tilde_key.fkey_number = 4'(acc - 7'd11);
      end
      7'd23: begin
        tilde_key.kind = ted_pkg::KIND_FKEY; tilde_key.fkey_number = 4'd11;
      end
      7'd24: begin
        tilde_key.kind = ted_pkg::KIND_FKEY; tilde_key.fkey_number = 4'd12;
      end
      default: tilde_key.kind = ted_pkg::KIND_UNKNOWN;
    endcase
  end

  always_comb begin
    key = '{valid: 1'b1, kind: ted_pkg::KIND_UNKNOWN, char_code: 7'd0,
            nav_index: 4'd0, fkey_number: 4'd0};
    // Any result drops back to idle
    mode_nxt = ted_pkg::MODE_IDLE;
    acc_nxt  = 7'd0;
    case (mode)
      ted_pkg::MODE_ESC: begin
        if (!func && data_byte == ted_pkg::BYTE_CSI) begin
          key.valid = 1'b0;
          mode_nxt  = ted_pkg::MODE_CSI;
        end else if (!func && data_byte == ted_pkg::BYTE_SS3) begin
          key.valid = 1'b0;
          mode_nxt  = ted_pkg::MODE_SS3;
        end else begin
          key.kind = ted_pkg::KIND_ESC;
        end
      end
      ted_pkg::MODE_CSI: begin
        if (func) begin
          key.kind = ted_pkg::KIND_ESC;
        end else if (is_digit) begin
          key.valid = 1'b0;
          mode_nxt  = ted_pkg::MODE_NUM;
          acc_nxt   = {3'd0, digit_val};
        end else begin
          case (data_byte)
            8'h41: begin key.kind = ted_pkg::KIND_NAV; key.nav_index = ted_pkg::NAV_UP; end
            8'h42: begin key.kind = ted_pkg::KIND_NAV; key.nav_index = ted_pkg::NAV_DOWN; end
            8'h43: begin key.kind = ted_pkg::KIND_NAV; key.nav_index = ted_pkg::NAV_RIGHT; end
            8'h44: begin key.kind = ted_pkg::KIND_NAV; key.nav_index = ted_pkg::NAV_LEFT; end
            8'h48: begin key.kind = ted_pkg::KIND_NAV; key.nav_index = ted_pkg::NAV_HOME; end
            8'h46: begin key.kind = ted_pkg::KIND_NAV; key.nav_index = ted_pkg::NAV_END; end
            8'h5A: key.kind = ted_pkg::KIND_TAB;
            default: key.kind = ted_pkg::KIND_UNKNOWN;
          endcase
        end
      end
      ted_pkg::MODE_NUM: begin
        if (!func && is_digit) begin
          key.valid = 1'b0;
          mode_nxt  = ted_pkg::MODE_NUM;
          acc_nxt   = (acc_grow > 10'(ted_pkg::ACC_MAX)) ? ted_pkg::ACC_MAX : acc_grow[6:0];
        end else if (!func && data_byte == ted_pkg::BYTE_TILDE) begin
          key = tilde_key;
        end
      end
      ted_pkg::MODE_SS3: begin
        if (!func && data_byte >= 8'h50 && data_byte <= 8'h53) begin
          key.kind        = ted_pkg::KIND_FKEY;
          key.fkey_number = {2'b00, data_byte[1:0]} + 4'd1;
        end
      end
      default: begin
        // Idle, and any stray code treated as idle
        if (func) begin
          key.valid = 1'b0;
        end else if (data_byte == ted_pkg::BYTE_ESC) begin
          key.valid = 1'b0;
          mode_nxt  = ted_pkg::MODE_ESC;
        end else begin
          key = plain_key;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/terminal_escape_key_decoder.sv]
// Top level of the terminal escape key decoder: state, result register, handshakes.
`timescale 1ns / 1ps
`default_nettype none
// Takes one terminal byte (or an idle tick, in_func high) per request and gives at most one
// key event per request: printables with letters in upper case, Enter, Tab, Backspace, Escape,
// navigation keys and F1 to F12 from VT100/ANSI escape sequences. A request is accepted in
// every cycle in which in_stall is low; its key event, if any, is then registered in the result
// register. The only limit on rate is that single result register: input stalls while a key
// event is held there with out_stall high. An idle tick resolves a pending lone escape.
module terminal_escape_key_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_func,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_kind,
  output logic [6:0]      out_char_code,
  output logic [3:0]      out_nav_index,
  output logic [3:0]      out_fkey_number
);

  ted_pkg::mode_t mode_r;
  ted_pkg::mode_t mode_nxt;
  logic [6:0]     acc_r;
  logic [6:0]     acc_nxt;
  ted_pkg::key_t  key;
  logic           in_accept;
  logic           out_valid_r;
  logic [2:0]     kind_r;
  logic [6:0]     char_code_r;
  logic [3:0]     nav_index_r;
  logic [3:0]     fkey_number_r;

  ted_decode u_decode (
    .mode      (mode_r),
    .acc       (acc_r),
    .func      (in_func),
    .data_byte (in_data_byte),
    .mode_nxt  (mode_nxt),
    .acc_nxt   (acc_nxt),
    .key       (key)
  );

  // Hold input only while a result waits and the consumer stalls
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ted_pkg::MODE_IDLE;
      acc_r       <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      // A new key event replaces one that drains in the same cycle
      if (in_accept && key.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_accept) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && key.valid) begin
      kind_r        <= key.kind;
      char_code_r   <= key.char_code;
      nav_index_r   <= key.nav_index;
      fkey_number_r <= key.fkey_number;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_char_code   = char_code_r;
  assign out_nav_index   = nav_index_r;
  assign out_fkey_number = fkey_number_r;

  a_char_only_print: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != ted_pkg::KIND_PRINT |-> char_code_r == 7'd0)
    else $error("char_code set on a non-printable key");

  a_fkey_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == ted_pkg::KIND_FKEY |->
      fkey_number_r != 4'd0 && fkey_number_r <= 4'd12)
    else $error("function key number out of range");

  a_acc_sat: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= ted_pkg::ACC_MAX)
    else $error("sequence number above saturation limit");

  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != ted_pkg::MODE_NUM |-> acc_r == 7'd0)
    else $error("sequence number left over outside a number");

  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && key.valid |=> mode_r == ted_pkg::MODE_IDLE)
    else $error("parser not back to idle after a key event");

endmodule
`default_nettype wire
